>>> rtl/pid_with_measured_dt_core_macros.svh
// Assertion helpers used by the bound checker of the PID core.
`ifndef PID_WITH_MEASURED_DT_CORE_MACROS_SVH
`define PID_WITH_MEASURED_DT_CORE_MACROS_SVH

// Same-cycle implication.
`define PWMD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PWMD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pwmd_pkg.sv
`timescale 1ns / 1ps
package pwmd_pkg;

   localparam int COUNTER_BITS = 24;
   localparam int RATE_W       = 27;
   localparam int MUL_W        = 33;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int DIV_W        = 60;
   localparam int DIV_STEPS    = DIV_W;
   localparam int CNT_W        = 6;
   localparam int SUM_W        = 48;
   localparam int FSUM_W       = 50;

   localparam logic [RATE_W-1:0] FALLBACK_DEN = RATE_W'(1000);
   localparam logic [16:0]       WEIGHT_ONE   = 17'h10000;

   // register indexes
   localparam logic [2:0] CSR_GAIN_P     = 3'd0;
   localparam logic [2:0] CSR_GAIN_I     = 3'd1;
   localparam logic [2:0] CSR_GAIN_D     = 3'd2;
   localparam logic [2:0] CSR_FILT_W     = 3'd3;
   localparam logic [2:0] CSR_INT_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_DRV_LIMIT  = 3'd5;
   localparam logic [2:0] CSR_TICK_RATE  = 3'd6;

   typedef struct packed {
      logic signed [31:0]       measured;
      logic signed [31:0]       setpoint;
      logic [COUNTER_BITS-1:0]  tick_now;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               clamped;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL_P,
      ST_MUL_INC,
      ST_DIV_I_LD,
      ST_DIV_I,
      ST_INT_UPD,
      ST_MUL_ILO,
      ST_MUL_IHI,
      ST_I_TERM,
      ST_MUL_RAW,
      ST_DIV_R_LD,
      ST_DIV_R,
      ST_RAW,
      ST_MUL_F1,
      ST_MUL_F2,
      ST_F_ADD,
      ST_FILT,
      ST_MUL_D,
      ST_D_TERM,
      ST_DONE
   } state_type;

endpackage

>>> rtl/pid_with_measured_dt_core.sv
`timescale 1ns / 1ps
// PID controller with measured elapsed time and low-pass filtered derivative.
// Input channel req_*: one item carries measured, setpoint and the current
// value of a down-counting tick counter. Result channel rsp_*: one item per
// input, the drive (signed Q16.16, clamped to +/- drive_limit) and a flag set
// when the clamp cut the sum.
// Registers are written through csr_wr_en / csr_index / csr_wdata; the user
// must write them only while idle, which the block does not enforce. All
// arithmetic runs on one 33x33 multiplier and one bit-per-cycle restoring
// divider (60 steps, used twice per item) under a sequencer, so one item is
// in work at a time; a new item is taken the cycle after the result is
// loaded. The result sits in an output register; a stalled receiver holds
// it, and the core still takes and works on the next item, waiting at its
// end until the output register is free.
// Reset (synchronous) restores register defaults and clears the integral
// sum, the previous error, the filtered slope and the stored tick value.
module pid_with_measured_dt_core
   import pwmd_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int ACC_W = 68 - FRACTION_BITS;
   localparam logic [COUNTER_BITS-1:0] TICK_MASK = {COUNTER_BITS{1'b1}};

   state_type state_ff, state_in;

   logic [31:0]        gain_p_ff, gain_i_ff, gain_d_ff;
   logic [16:0]        filt_w_ff;
   logic [30:0]        int_limit_ff, drv_limit_ff;
   logic [RATE_W-1:0]  tick_rate_ff;

   req_type            in_ff, in_in;
   logic [31:0]        err_ff, err_in;
   logic [32:0]        diff_ff, diff_in;
   logic [RATE_W-1:0]  num_ff, num_in, den_ff, den_in;
   logic               neg_ff, neg_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [SUM_W-1:0]   integ_ff, integ_in;
   logic [63:0]        ilo_ff, ilo_in;
   logic [31:0]        raw_ff, raw_in;
   logic [FSUM_W-1:0]  fsum_ff, fsum_in;
   logic [31:0]        fslope_ff, fslope_in;
   logic [31:0]        last_err_ff, last_err_in;
   logic [COUNTER_BITS-1:0] last_tick_ff, last_tick_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIV_W-1:0]   dq_ff, dq_in;
   logic [RATE_W-1:0]  rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // operand magnitudes
   logic [32:0]        err_x, err_mag, raw_x, raw_mag, fs_x, fs_mag;
   logic [33:0]        diff_x, diff_neg;
   logic [32:0]        diff_mag;
   logic [SUM_W-1:0]   int_mag;
   logic [16:0]        w_eff, w_rest;
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]  prod_sh;
   logic [ACC_W-1:0]   term;

   // prep
   logic [32:0]        sdiff;
   logic [31:0]        err_new;
   logic [COUNTER_BITS-1:0] elapsed;
   logic               fallback;

   // divider step
   logic [RATE_W:0]    shifted;
   logic [RATE_W+1:0]  trial;

   // misc
   logic [SUM_W:0]     int_wide;
   logic [SUM_W-1:0]   inc;
   logic [79:0]        int_total, int_q;
   logic [30:0]        int_term;
   logic [FSUM_W-1:0]  f_prod, f_neg;
   logic [FSUM_W-1:0]  f_sh;
   logic [ACC_W-1:0]   lim_pos, lim_neg;

   assign err_x    = {err_ff[31], err_ff};
   assign err_mag  = err_x[32] ? (~err_x + 33'd1) : err_x;
   assign raw_x    = {raw_ff[31], raw_ff};
   assign raw_mag  = raw_x[32] ? (~raw_x + 33'd1) : raw_x;
   assign fs_x     = {fslope_ff[31], fslope_ff};
   assign fs_mag   = fs_x[32] ? (~fs_x + 33'd1) : fs_x;
   assign diff_x   = {diff_ff[32], diff_ff};
   assign diff_neg = ~diff_x + 34'd1;
   assign diff_mag = diff_x[33] ? diff_neg[32:0] : diff_x[32:0];
   assign int_mag  = integ_ff[SUM_W-1] ? (~integ_ff + SUM_W'(1)) : integ_ff;
   assign w_eff    = filt_w_ff[16] ? WEIGHT_ONE : filt_w_ff;
   assign w_rest   = WEIGHT_ONE - w_eff;

   assign prod_sh  = prod_ff >> FRACTION_BITS;
   assign term     = prod_sh[ACC_W-1:0];

   assign shifted  = {rem_ff, dq_ff[DIV_W-1]};
   assign trial    = {1'b0, shifted} - {2'b00, dvsr_ff};

   assign lim_pos  = ACC_W'(drv_limit_ff);
   assign lim_neg  = ~lim_pos + ACC_W'(1);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_P: begin
            mul_a = err_mag;
            mul_b = {1'b0, gain_p_ff};
         end
         ST_MUL_INC: begin
            mul_a = err_mag;
            mul_b = MUL_W'(num_ff);
         end
         ST_MUL_ILO: begin
            mul_a = {1'b0, int_mag[31:0]};
            mul_b = {1'b0, gain_i_ff};
         end
         ST_MUL_IHI: begin
            mul_a = MUL_W'(int_mag[SUM_W-1:32]);
            mul_b = {1'b0, gain_i_ff};
         end
         ST_MUL_RAW: begin
            mul_a = diff_mag;
            mul_b = MUL_W'(den_ff);
         end
         ST_MUL_F1: begin
            mul_a = MUL_W'(w_eff);
            mul_b = raw_mag;
         end
         ST_MUL_F2: begin
            mul_a = MUL_W'(w_rest);
            mul_b = fs_mag;
         end
         ST_MUL_D: begin
            mul_a = fs_mag;
            mul_b = {1'b0, gain_d_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      sdiff   = {in_ff.setpoint[31], in_ff.setpoint} - {in_ff.measured[31], in_ff.measured};
      if (sdiff[32] != sdiff[31]) begin
         err_new = sdiff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         err_new = sdiff[31:0];
      end
      if (in_ff.tick_now < last_tick_ff) begin
         elapsed = last_tick_ff - in_ff.tick_now;
      end else begin
         elapsed = TICK_MASK - in_ff.tick_now + last_tick_ff;
      end
      fallback = (elapsed == '0) ||
                 ({{(33 - COUNTER_BITS){1'b0}}, elapsed, 1'b0} > {7'b0, tick_rate_ff});

      inc       = neg_ff ? (~dq_ff[SUM_W-1:0] + SUM_W'(1)) : dq_ff[SUM_W-1:0];
      int_wide  = {integ_ff[SUM_W-1], integ_ff} + {inc[SUM_W-1], inc};

      int_total = {16'b0, ilo_ff} + {prod_ff[47:0], 32'b0};
      int_q     = int_total >> FRACTION_BITS;
      int_term  = (int_q > 80'(int_limit_ff)) ? int_limit_ff : int_q[30:0];

      f_prod    = FSUM_W'(prod_ff[48:0]);
      f_neg     = ~fsum_ff + FSUM_W'(1);
      // divide by 65536, rounding toward zero
      f_sh      = fsum_ff[FSUM_W-1] ? (f_neg >> 16) : (fsum_ff >> 16);
   end

   always_comb begin
      state_in     = state_ff;
      in_in        = in_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      integ_in     = integ_ff;
      ilo_in       = ilo_ff;
      raw_in       = raw_ff;
      fsum_in      = fsum_ff;
      fslope_in    = fslope_ff;
      last_err_in  = last_err_ff;
      last_tick_in = last_tick_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      dvsr_in      = dvsr_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_in    = req_data;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            err_in  = err_new;
            diff_in = {err_new[31], err_new} - {last_err_ff[31], last_err_ff};
            num_in  = fallback ? RATE_W'(1) : RATE_W'(elapsed);
            den_in  = fallback ? FALLBACK_DEN : tick_rate_ff;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            state_in = ST_MUL_INC;
         end
         ST_MUL_INC: begin
            acc_in   = err_ff[31] ? (~term + ACC_W'(1)) : term;
            state_in = ST_DIV_I_LD;
         end
         ST_DIV_I_LD, ST_DIV_R_LD: begin
            dq_in  = prod_ff[DIV_W-1:0];
            rem_in = '0;
            cnt_in = '0;
            if (state_ff == ST_DIV_I_LD) begin
               dvsr_in  = den_ff;
               neg_in   = err_ff[31];
               state_in = ST_DIV_I;
            end else begin
               dvsr_in  = num_ff;
               neg_in   = diff_ff[32];
               state_in = ST_DIV_R;
            end
         end
         ST_DIV_I, ST_DIV_R: begin
            rem_in = trial[RATE_W+1] ? shifted[RATE_W-1:0] : trial[RATE_W-1:0];
            dq_in  = {dq_ff[DIV_W-2:0], ~trial[RATE_W+1]};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = (state_ff == ST_DIV_I) ? ST_INT_UPD : ST_RAW;
            end
         end
         ST_INT_UPD: begin
            if (int_wide[SUM_W] != int_wide[SUM_W-1]) begin
               integ_in = int_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                          : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
               integ_in = int_wide[SUM_W-1:0];
            end
            state_in = ST_MUL_ILO;
         end
         ST_MUL_ILO: begin
            state_in = ST_MUL_IHI;
         end
         ST_MUL_IHI: begin
            ilo_in   = prod_ff[63:0];
            state_in = ST_I_TERM;
         end
         ST_I_TERM: begin
            acc_in   = integ_ff[SUM_W-1] ? (acc_ff - ACC_W'(int_term))
                                         : (acc_ff + ACC_W'(int_term));
            state_in = ST_MUL_RAW;
         end
         ST_MUL_RAW: begin
            state_in = ST_DIV_R_LD;
         end
         ST_RAW: begin
            if (!neg_ff) begin
               raw_in = (dq_ff > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : dq_ff[31:0];
            end else begin
               raw_in = (dq_ff >= DIV_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                                 : (~dq_ff[31:0] + 32'd1);
            end
            state_in = ST_MUL_F1;
         end
         ST_MUL_F1: begin
            state_in = ST_MUL_F2;
         end
         ST_MUL_F2: begin
            fsum_in  = raw_ff[31] ? (~f_prod + FSUM_W'(1)) : f_prod;
            state_in = ST_F_ADD;
         end
         ST_F_ADD: begin
            fsum_in  = fslope_ff[31] ? (fsum_ff - f_prod) : (fsum_ff + f_prod);
            state_in = ST_FILT;
         end
         ST_FILT: begin
            fslope_in = fsum_ff[FSUM_W-1] ? (~f_sh[31:0] + 32'd1) : f_sh[31:0];
            state_in  = ST_MUL_D;
         end
         ST_MUL_D: begin
            state_in = ST_D_TERM;
         end
         ST_D_TERM: begin
            acc_in   = fslope_ff[31] ? (acc_ff - term) : (acc_ff + term);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || !rsp_stall) begin
               if ($signed(acc_ff) > $signed(lim_pos)) begin
                  rsp_data_in.drive   = lim_pos[31:0];
                  rsp_data_in.clamped = 1'b1;
               end else if ($signed(acc_ff) < $signed(lim_neg)) begin
                  rsp_data_in.drive   = lim_neg[31:0];
                  rsp_data_in.clamped = 1'b1;
               end else begin
                  rsp_data_in.drive   = acc_ff[31:0];
                  rsp_data_in.clamped = 1'b0;
               end
               rsp_valid_in = 1'b1;
               last_err_in  = err_ff;
               last_tick_in = in_ff.tick_now;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_err_ff  <= '0;
         fslope_ff    <= '0;
         last_tick_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         last_err_ff  <= last_err_in;
         fslope_ff    <= fslope_in;
         last_tick_ff <= last_tick_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      ilo_ff      <= ilo_in;
      raw_ff      <= raw_in;
      fsum_ff     <= fsum_in;
      prod_ff     <= prod_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      dvsr_ff     <= dvsr_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= 32'd6554;
         gain_i_ff    <= 32'd131072;
         gain_d_ff    <= 32'd0;
         filt_w_ff    <= WEIGHT_ONE;
         int_limit_ff <= 31'd6553600;
         drv_limit_ff <= 31'd6553600;
         tick_rate_ff <= RATE_W'(9000000);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN_P:    gain_p_ff    <= csr_wdata;
            CSR_GAIN_I:    gain_i_ff    <= csr_wdata;
            CSR_GAIN_D:    gain_d_ff    <= csr_wdata;
            CSR_FILT_W:    filt_w_ff    <= csr_wdata[16:0];
            CSR_INT_LIMIT: int_limit_ff <= csr_wdata[30:0];
            CSR_DRV_LIMIT: drv_limit_ff <= csr_wdata[30:0];
            CSR_TICK_RATE: tick_rate_ff <= csr_wdata[RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/pwmd_checker.sv
`timescale 1ns / 1ps
`include "pid_with_measured_dt_core_macros.svh"
module pwmd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   `PWMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   // an accepted item keeps the core busy
   `PWMD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "core not busy after accept")

   // a new result only comes from an item in work
   `PWMD_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall), "result without item in work")

   `PWMD_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

bind pid_with_measured_dt_core pwmd_checker u_pwmd_checker (.*);

>>> dv/pid_checker.sv
`timescale 1ns / 1ps
module pid_checker
   import pwmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          drives_due
);

   localparam int FRAC = 16;
   localparam longint TERM_CAP = longint'(1) << 62;
   localparam longint ISUM_MAX = (longint'(1) << 47) - 1;
   localparam longint ISUM_MIN = -(longint'(1) << 47);
   localparam longint I32_MAX = 64'sd2147483647;
   localparam longint I32_MIN = -64'sd2147483648;
   localparam longint TICK_MASK = 64'hFFFFFF;

   longint kp, ki, kd, weight, int_lim, drv_lim, rate;
   longint integ, prev_err, slope, prev_tick;
   rsp_type drive_q[$];

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // magnitude times gain, truncated, capped, sign restored
   function automatic longint apply_gain(longint v, longint g, longint cap);
      logic [63:0]  mag;
      logic [127:0] prod;
      logic [63:0]  q;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      if (mag == 0 || g == 0) return 0;
      prod = {64'd0, mag} * {64'd0, 64'(g)};
      if (prod[127:64] != 0) begin
         q = 64'(cap);
      end else begin
         q = prod[63:0] >> FRAC;
         if (q > 64'(cap)) q = 64'(cap);
      end
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic rsp_type next_drive(req_type it);
      longint now, e, num, den, err, p, i, raw, w, filt, d, sum;
      rsp_type r;
      now = longint'(it.tick_now);
      e = (now < prev_tick) ? prev_tick - now : TICK_MASK - now + prev_tick;
      if (e == 0 || 2 * e > rate) begin
         num = 1;
         den = 1000;
      end else begin
         num = e;
         den = rate;
      end
      err = clip(longint'(it.setpoint) - longint'(it.measured), I32_MIN, I32_MAX);
      p = apply_gain(err, kp, TERM_CAP);
      integ = clip(integ + (err * num) / den, ISUM_MIN, ISUM_MAX);
      i = apply_gain(integ, ki, int_lim);
      raw = clip(((err - prev_err) * den) / num, I32_MIN, I32_MAX);
      w = (weight > 65536) ? 65536 : weight;
      filt = (w * raw + (65536 - w) * slope) / 65536;
      slope = filt;
      d = apply_gain(filt, kd, TERM_CAP);
      sum = p + i + d;
      r.clamped = 1'b0;
      if (sum > drv_lim) begin
         sum = drv_lim;
         r.clamped = 1'b1;
      end else if (sum < -drv_lim) begin
         sum = -drv_lim;
         r.clamped = 1'b1;
      end
      r.drive = sum[31:0];
      prev_err = err;
      prev_tick = now;
      return r;
   endfunction

   task automatic report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         kp = 6554; ki = 131072; kd = 0; weight = 65536;
         int_lim = 6553600; drv_lim = 6553600; rate = 9000000;
         integ = 0; prev_err = 0; slope = 0; prev_tick = 0;
         drive_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GAIN_P:    kp = longint'(csr_wdata);
               CSR_GAIN_I:    ki = longint'(csr_wdata);
               CSR_GAIN_D:    kd = longint'(csr_wdata);
               CSR_FILT_W:    weight = longint'(csr_wdata[16:0]);
               CSR_INT_LIMIT: int_lim = longint'(csr_wdata[30:0]);
               CSR_DRV_LIMIT: drv_lim = longint'(csr_wdata[30:0]);
               CSR_TICK_RATE: rate = longint'(csr_wdata[26:0]);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) drive_q.push_back(next_drive(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (drive_q.size() == 0) begin
               report("result item with nothing expected");
            end else begin
               want = drive_q.pop_front();
               if (rsp_data.drive !== want.drive)
                  report($sformatf("drive %h, want %h", rsp_data.drive, want.drive));
               if (rsp_data.clamped !== want.clamped)
                  report($sformatf("clamped %b, want %b", rsp_data.clamped, want.clamped));
            end
         end
      end
      drives_due = drive_q.size();
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
   import pwmd_pkg::*;

   localparam int STALL_LIMIT = 6000;
   localparam int SETTLE = 160;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = CSR_GAIN_P;
   logic [31:0] csr_wdata = '0;
   int          fail_count, drives_due;

   int          tx_idle_pct = 0, rx_idle_pct = 0;
   logic        hold_request = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   logic [23:0] tick_cur = 24'd0;
   int unsigned cur_rate = 9000000;

   int unsigned settings[6][7] = '{
      '{6554, 131072, 3277, 65536, 6553600, 6553600, 9000000},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 134217727},
      '{0, 0, 0, 1, 0, 0, 1},
      '{65536, 20000, 40, 131071, 1000000, 20000000, 1000000},
      '{3000, 500000, 700, 32768, 32'h7FFFFFFF, 3000000, 1000},
      '{100000, 65536, 1, 16384, 500000, 32'h7FFFFFFF, 50000}
   };

   pid_with_measured_dt_core dut (.*);

   pid_checker checker_i (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_request && hold_left == 0) begin
         hold_left <= 600;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_setting(int unsigned s[7]);
      write_reg(CSR_GAIN_P, s[0]);
      write_reg(CSR_GAIN_I, s[1]);
      write_reg(CSR_GAIN_D, s[2]);
      write_reg(CSR_FILT_W, s[3]);
      write_reg(CSR_INT_LIMIT, s[4]);
      write_reg(CSR_DRV_LIMIT, s[5]);
      write_reg(CSR_TICK_RATE, s[6]);
      cur_rate = s[6] & 32'h7FFFFFF;
   endtask

   // stop offering so the last item is not taken again once the core is idle
   task automatic drain();
      req_valid <= 1'b0;
      wait (drives_due == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // valid stays high across back-to-back items; only dropped for a gap
   task automatic send_item(logic signed [31:0] meas, logic signed [31:0] target,
                            logic [23:0] tick);
      int gap;
      if ($urandom_range(99) < tx_idle_pct) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{measured: meas, setpoint: target, tick_now: tick};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_item();
      logic signed [31:0] meas, target;
      int unsigned step;
      if ($urandom_range(99) < 80) begin
         step = $urandom_range(1, cur_rate / 400 + 1);
         tick_cur = tick_cur - step[23:0];
         meas = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
         target = ($urandom_range(9) == 0) ? $urandom()
                  : $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
      end else begin
         tick_cur = $urandom();
         meas = $urandom();
         target = $urandom();
      end
      send_item(meas, target, tick_cur);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unit proportional gain, no I or D, limit of 100.0
      load_setting('{65536, 0, 0, 65536, 6553600, 100 << 16, 9000000});
      send_item(32'sh80000000, 32'sh7FFFFFFF, 24'd0);
      send_item(32'sh7FFFFFFF, 32'sh80000000, 24'hFFFFFF);
      send_item(0, 100 << 16, 24'hFFFFFF - 24'd9000);
      send_item(0, (100 << 16) + 1, 24'd100);
      send_item(100 << 16, 0, 24'hFFFF00);
      send_item((100 << 16) + 1, 0, 24'hFFFF00 - 24'd8999999);
      send_item(0, 0, 24'd5);
      drain();
      load_setting(settings[0]);
      send_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'd5);
      send_item(0, 32'sh7FFFFFFF, 24'd4);
      send_item(32'sh80000000, 0, 24'd2);
      send_item(0, 32'sh00010000, 24'hFFFFF0);
      send_item(32'sh00050000, 0, 24'hFFFFF0 - 24'd3000);
      send_item(-1, 1, 24'd0);
      tick_cur = 24'd0;

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         load_setting(settings[ph]);
         tx_idle_pct = (ph % 3 == 0) ? 21 : ((ph % 3 == 1) ? 47 : 0);
         rx_idle_pct = (ph % 3 == 0) ? 47 : ((ph % 3 == 1) ? 21 : 0);
         if (ph == 1) hold_request <= 1'b1;
         for (int n = 0; n < 140; n++) begin
            if (n == 20) hold_request <= 1'b0;
            if (n == 70 && ph == 2) begin
               req_valid <= 1'b0;
               wait (drives_due == 0);
               @(posedge clock);
            end
            random_item();
         end
      end
      req_valid <= 1'b0;
      drain();

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/pwmd_pkg.sv
rtl/pid_with_measured_dt_core.sv
rtl/pwmd_checker.sv
dv/pid_checker.sv
dv/tb.sv
